@@ sv/xtea_block_cipher_assert.svh @@
// ----------------------------------------------------------------------------
// xtea_block_cipher_assert.svh
// Assertion macros used by the XTEA engine RTL.
// ----------------------------------------------------------------------------
`ifndef XTEA_BLOCK_CIPHER_ASSERT_SVH
`define XTEA_BLOCK_CIPHER_ASSERT_SVH

// same-cycle implication, sampled on clk, held off during reset
`define XTEA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("xtea: same-cycle check failed");

// next-cycle implication
`define XTEA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("xtea: next-cycle check failed");

`endif

@@ sv/xtea_pkg.sv @@
// ----------------------------------------------------------------------------
// xtea_pkg
// Word types, register indexes, microcode format and program for the XTEA
// engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package xtea_pkg;

  localparam int unsigned HALF_W     = 32;
  localparam int unsigned ROUNDS_W   = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned PC_W       = 4;

  localparam logic [HALF_W-1:0]   XTEA_DELTA     = 32'h9E37_79B9;
  // delta * 32 mod 2^32, the decrypt start sum for the reset round count
  localparam logic [HALF_W-1:0]   DEC_SUM_RESET  = 32'hC6EF_3720;
  localparam logic [ROUNDS_W-1:0] ROUNDS_RESET   = 8'd32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_1  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_2  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_3  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ROUND_COUNT = 3'd4;

  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  typedef struct packed {
    logic              opcode;
    logic [HALF_W-1:0] data_first;
    logic [HALF_W-1:0] data_second;
  } xtea_in_t;

  typedef struct packed {
    logic [HALF_W-1:0] result_first;
    logic [HALF_W-1:0] result_second;
  } xtea_out_t;

  // jump conditions
  localparam logic [2:0] C_NEVER    = 3'd0;
  localparam logic [2:0] C_ALWAYS   = 3'd1;
  localparam logic [2:0] C_NO_IN    = 3'd2;
  localparam logic [2:0] C_CNT_ZERO = 3'd3;
  localparam logic [2:0] C_IS_DEC   = 3'd4;
  localparam logic [2:0] C_MORE     = 3'd5;
  localparam logic [2:0] C_OUT_BUSY = 3'd6;

  // program addresses
  localparam logic [PC_W-1:0] PC_WAIT     = 4'd0;
  localparam logic [PC_W-1:0] PC_ZERO     = 4'd1;
  localparam logic [PC_W-1:0] PC_DISPATCH = 4'd2;
  localparam logic [PC_W-1:0] PC_ENC_X    = 4'd3;
  localparam logic [PC_W-1:0] PC_ENC_Y    = 4'd4;
  localparam logic [PC_W-1:0] PC_ENC_END  = 4'd5;
  localparam logic [PC_W-1:0] PC_DEC_Y    = 4'd6;
  localparam logic [PC_W-1:0] PC_DEC_X    = 4'd7;
  localparam logic [PC_W-1:0] PC_DEC_END  = 4'd8;
  localparam logic [PC_W-1:0] PC_EMIT     = 4'd15;

  // one control word; jump to target when cond holds, else step on
  typedef struct packed {
    logic            load;     // take an input word
    logic            emit;     // write the output register
    logic            wr_x;     // half-round on x (mix of y)
    logic            wr_y;     // half-round on y (mix of x)
    logic            sub;      // decrypt direction
    logic            s_step;   // move the sum by delta
    logic            cnt_dec;  // one round finished
    logic [2:0]      cond;
    logic [PC_W-1:0] target;
  } xtea_uop_t;

  function automatic xtea_uop_t xtea_ucode(input logic [PC_W-1:0] pc);
    xtea_uop_t u;
    u = '0;
    case (pc)
      PC_WAIT: begin
        u.load = 1'b1; u.cond = C_NO_IN; u.target = PC_WAIT;
      end
      PC_ZERO: begin
        u.cond = C_CNT_ZERO; u.target = PC_EMIT;
      end
      PC_DISPATCH: begin
        u.cond = C_IS_DEC; u.target = PC_DEC_Y;
      end
      PC_ENC_X: begin
        u.wr_x = 1'b1; u.s_step = 1'b1; u.cond = C_NEVER;
      end
      PC_ENC_Y: begin
        u.wr_y = 1'b1; u.cnt_dec = 1'b1; u.cond = C_MORE; u.target = PC_ENC_X;
      end
      PC_ENC_END: begin
        u.cond = C_ALWAYS; u.target = PC_EMIT;
      end
      PC_DEC_Y: begin
        u.wr_y = 1'b1; u.sub = 1'b1; u.s_step = 1'b1; u.cond = C_NEVER;
      end
      PC_DEC_X: begin
        u.wr_x = 1'b1; u.sub = 1'b1; u.cnt_dec = 1'b1;
        u.cond = C_MORE; u.target = PC_DEC_Y;
      end
      PC_DEC_END: begin
        u.cond = C_ALWAYS; u.target = PC_EMIT;
      end
      PC_EMIT: begin
        // falls through to address zero by wrap-around
        u.emit = 1'b1; u.cond = C_OUT_BUSY; u.target = PC_EMIT;
      end
      default: begin
        u.cond = C_ALWAYS; u.target = PC_WAIT;
      end
    endcase
    return u;
  endfunction

  function automatic logic [HALF_W-1:0] xtea_mix(input logic [HALF_W-1:0] h);
    return ((h << 4) ^ (h >> 5)) + h;
  endfunction

endpackage

`default_nettype wire

@@ sv/xtea_block_cipher.sv @@
// ----------------------------------------------------------------------------
// xtea_block_cipher
// XTEA engine, 64-bit block, 128-bit key, run by a small microcode program.
// ----------------------------------------------------------------------------
// An input word carries an opcode (encrypt/decrypt) and the block as two
// 32-bit halves; each word yields exactly one output word. The user must
// write key words and the round count on the cfg port only while the engine
// is idle; the block itself does not enforce this (indexes 0..3 key words,
// 4 round count, others ignored). A 16-entry microcode ROM steps a single
// half-round datapath: one half-round per cycle, with the x and y
// half-rounds of each round framed by the zero-round test, dispatch, end
// and emit steps of the program. The engine takes one item at a time;
// the finished word sits in the output register, so the next input word is
// taken while the last result is still stalled. The decrypt start sum
// (delta * rounds) is formed when the round count is written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module xtea_block_cipher import xtea_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // input words
  input  logic                  in_valid,
  output logic                  in_stall,
  input  xtea_in_t              in_word,
  // output words
  output logic                  out_valid,
  input  logic                  out_stall,
  output xtea_out_t             out_word
);

  // configuration registers
  logic [HALF_W-1:0]   key_r [4];
  logic [ROUNDS_W-1:0] rounds_r;
  logic [HALF_W-1:0]   dec_sum_r;

  // sequencer
  logic [PC_W-1:0]     pc_r, pc_nxt;
  xtea_uop_t           uop;
  logic                jump;

  // datapath
  logic                op_r;
  logic [HALF_W-1:0]   x_r, y_r, s_r;
  logic [ROUNDS_W-1:0] cnt_r;
  logic [HALF_W-1:0]   mix_src, round_f, acc, acc_new, s_new;
  logic [1:0]          key_idx;

  // output register
  logic                out_valid_r;
  xtea_out_t           out_word_r;

  logic in_take, out_take, out_blocked;

  assign uop         = xtea_ucode(pc_r);
  assign in_stall    = !uop.load;
  assign in_take     = in_valid && uop.load;
  assign out_take    = out_valid_r && !out_stall;
  assign out_blocked = out_valid_r && out_stall;
  assign out_valid   = out_valid_r;
  assign out_word    = out_word_r;

  // --- jump condition and next step ---
  always_comb begin
    case (uop.cond)
      C_NEVER:    jump = 1'b0;
      C_ALWAYS:   jump = 1'b1;
      C_NO_IN:    jump = !in_valid;
      C_CNT_ZERO: jump = (cnt_r == '0);
      C_IS_DEC:   jump = (op_r == OP_DECRYPT);
      C_MORE:     jump = (cnt_r != ROUNDS_W'(1));
      C_OUT_BUSY: jump = out_blocked;
      default:    jump = 1'b0;
    endcase
    pc_nxt = jump ? uop.target : pc_r + PC_W'(1);
  end

  // --- half-round: acc +/- (mix(other) ^ (sum + key[sel])) ---
  // x uses sum bits 1:0, y uses sum bits 12:11
  always_comb begin
    mix_src = uop.wr_x ? y_r : x_r;
    acc     = uop.wr_x ? x_r : y_r;
    key_idx = uop.wr_x ? s_r[1:0] : s_r[12:11];
    round_f = xtea_mix(mix_src) ^ (s_r + key_r[key_idx]);
    acc_new = uop.sub ? (acc - round_f) : (acc + round_f);
    s_new   = uop.sub ? (s_r - XTEA_DELTA) : (s_r + XTEA_DELTA);
  end

  // --- configuration ---
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r[0]  <= '0;
      key_r[1]  <= '0;
      key_r[2]  <= '0;
      key_r[3]  <= '0;
      rounds_r  <= ROUNDS_RESET;
      dec_sum_r <= DEC_SUM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KEY_WORD_0:  key_r[0] <= cfg_data;
        CFG_KEY_WORD_1:  key_r[1] <= cfg_data;
        CFG_KEY_WORD_2:  key_r[2] <= cfg_data;
        CFG_KEY_WORD_3:  key_r[3] <= cfg_data;
        CFG_ROUND_COUNT: begin
          rounds_r  <= cfg_data[ROUNDS_W-1:0];
          // 32x8 product, wraps mod 2^32
          dec_sum_r <= HALF_W'(XTEA_DELTA * {{(HALF_W-ROUNDS_W){1'b0}},
                                             cfg_data[ROUNDS_W-1:0]});
        end
        default: ;
      endcase
    end
  end

  // --- sequencer ---
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PC_WAIT;
    end else if (!uop.load || in_take) begin
      pc_r <= pc_nxt;
    end
  end

  // --- working registers (no reset: always loaded before use) ---
  always_ff @(posedge clk) begin
    if (in_take) begin
      op_r  <= in_word.opcode;
      x_r   <= in_word.data_first;
      y_r   <= in_word.data_second;
      s_r   <= (in_word.opcode == OP_DECRYPT) ? dec_sum_r : '0;
      cnt_r <= rounds_r;
    end else begin
      if (uop.wr_x)    x_r   <= acc_new;
      if (uop.wr_y)    y_r   <= acc_new;
      if (uop.s_step)  s_r   <= s_new;
      if (uop.cnt_dec) cnt_r <= cnt_r - ROUNDS_W'(1);
    end
  end

  // --- output register ---
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (uop.emit && !out_blocked) begin
      out_valid_r <= 1'b1;
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (uop.emit && !out_blocked) begin
      out_word_r.result_first  <= x_r;
      out_word_r.result_second <= y_r;
    end
  end

  // --- checks ---
`include "xtea_block_cipher_assert.svh"

  // an accepted word starts the program at the zero-round test
  `XTEA_ASSERT_NEXT(a_take_starts, in_take, pc_r == PC_ZERO)
  // a round never finishes with the counter already spent
  `XTEA_ASSERT_NOW(a_cnt_live, uop.cnt_dec, cnt_r != '0)
  // the emit step that is not held back always presents a word
  `XTEA_ASSERT_NEXT(a_emit_shows, (pc_r == PC_EMIT) && !out_blocked, out_valid_r)
  // a fresh output word only comes from the emit step
  `XTEA_ASSERT_NOW(a_rise_from_emit, $rose(out_valid_r), $past(pc_r) == PC_EMIT)

endmodule

`default_nettype wire

@@ dv/tb_xtea_block_cipher.sv @@
// ----------------------------------------------------------------------------
// tb_xtea_block_cipher
// Self-checking bench for the XTEA engine. Every accepted input word is run
// through a local XTEA predictor under the bench's copy of the key and round
// count. Each output word is then compared, half by half, with the oldest
// prediction. Directed words cover data extremes, zero, one and 255 rounds,
// register masking and ignored indexes. Random traffic with encrypt/decrypt
// round trips follows, under several idle/stall mixes and a long output
// hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_xtea_block_cipher;
  import xtea_pkg::*;

  localparam int unsigned CLK_HALF       = 10;
  localparam logic [31:0] GOLDEN         = 32'h9E37_79B9;
  localparam logic [7:0]  RESET_ROUNDS   = 8'd32;
  // no acceptance on any port for this long means the engine has hung
  localparam int unsigned STALL_LIMIT    = 3000;
  localparam int unsigned HOLDOFF_CYCLES = 300;
  localparam int unsigned RANDOM_WORDS   = 115;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  xtea_in_t              in_word   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  xtea_out_t             out_word;

  xtea_block_cipher uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  // bench copy of the engine registers
  logic [31:0] cipher_key [4];
  logic [7:0]  round_total;

  // predicted output words, oldest first
  xtea_out_t expected_blocks [$];

  int error_count        = 0;
  int words_sent         = 0;
  int words_checked      = 0;
  int settings_used      = 0;
  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;
  int holdoff_left       = 0;
  int idle_cycles        = 0;

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic logic [31:0] half_mix(input logic [31:0] h);
    return ((h << 4) ^ (h >> 5)) + h;
  endfunction

  // Key word for the x half-round is picked by sum bits 1:0, for the y
  // half-round by sum bits 12:11. Decrypt walks the sum back down from
  // delta * rounds (mod 2^32).
  function automatic xtea_out_t predict_block(input xtea_in_t w);
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] s;
    xtea_out_t   r;
    x = w.data_first;
    y = w.data_second;
    if (w.opcode == OP_ENCRYPT) begin
      s = '0;
      for (int unsigned n = 0; n < round_total; n++) begin
        x += half_mix(y) ^ (s + cipher_key[s[1:0]]);
        s += GOLDEN;
        y += half_mix(x) ^ (s + cipher_key[s[12:11]]);
      end
    end else begin
      s = GOLDEN * {24'd0, round_total};
      for (int unsigned n = 0; n < round_total; n++) begin
        y -= half_mix(x) ^ (s + cipher_key[s[12:11]]);
        s -= GOLDEN;
        x -= half_mix(y) ^ (s + cipher_key[s[1:0]]);
      end
    end
    r.result_first  = x;
    r.result_second = y;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    error_count++;
  endtask

  // out_stall is sampled here before its own update at this edge lands
  always @(posedge clk) begin : result_check
    xtea_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_blocks.size() == 0) begin
        report_mismatch($sformatf("output word %h with nothing expected", out_word));
      end else begin
        want = expected_blocks.pop_front();
        words_checked++;
        if (out_word.result_first !== want.result_first)
          report_mismatch($sformatf("result_first %h, expected %h",
                                    out_word.result_first, want.result_first));
        if (out_word.result_second !== want.result_second)
          report_mismatch($sformatf("result_second %h, expected %h",
                                    out_word.result_second, want.result_second));
      end
    end
  end

  // Receiver: random stall, or a solid hold-off while holdoff_left counts
  // down. Only this block touches holdoff_left once it is non-zero.
  always @(posedge clk) begin
    if (holdoff_left != 0) begin
      out_stall    <= 1'b1;
      holdoff_left <= holdoff_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end
  end

  // Watchdog: any accepted word or register write resets the count
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Timeout: nothing accepted for %0d cycles", STALL_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  // Offers one word after a random idle gap and returns at the edge where it
  // is taken. in_valid is left high so back-to-back words need no toggle.
  task automatic send_word(input logic op, input logic [31:0] a, input logic [31:0] b);
    xtea_in_t w;
    int       gap;
    w.opcode      = op;
    w.data_first  = a;
    w.data_second = b;
    gap = 0;
    while ($urandom_range(99) < sender_idle_pct) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_blocks.push_back(predict_block(w));
    words_sent++;
  endtask

  // sender goes quiet until every predicted word has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_blocks.size() != 0) @(posedge clk);
  endtask

  // only called with the engine idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx <= CFG_KEY_WORD_3)
      cipher_key[idx[1:0]] = val;
    else if (idx == CFG_ROUND_COUNT)
      round_total = val[ROUNDS_W-1:0];
  endtask

  task automatic load_settings(input logic [31:0] k0, input logic [31:0] k1,
                               input logic [31:0] k2, input logic [31:0] k3,
                               input logic [31:0] rounds_val);
    drain_results();
    write_reg(CFG_KEY_WORD_0, k0);
    write_reg(CFG_KEY_WORD_1, k1);
    write_reg(CFG_KEY_WORD_2, k2);
    write_reg(CFG_KEY_WORD_3, k3);
    write_reg(CFG_ROUND_COUNT, rounds_val);
    settings_used++;
  endtask

  // random halves, with all-zero / all-one halves mixed in now and then
  function automatic logic [31:0] random_half();
    case ($urandom_range(15))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // reset key (all zero) and 32 rounds, no register written yet
  task automatic test_reset_defaults();
    send_word(OP_ENCRYPT, '0, '0);
    send_word(OP_DECRYPT, $urandom, $urandom);
  endtask

  task automatic test_data_extremes();
    load_settings('1, '1, '1, '1, 32'd32);
    send_word(OP_ENCRYPT, '0, '1);
    send_word(OP_ENCRYPT, '1, '0);
    send_word(OP_DECRYPT, '0, '0);
    send_word(OP_DECRYPT, '1, '1);
  endtask

  // zero rounds: both operations pass the block straight through
  task automatic test_zero_rounds();
    load_settings($urandom, $urandom, $urandom, $urandom, 32'd0);
    send_word(OP_ENCRYPT, $urandom, $urandom);
    send_word(OP_DECRYPT, $urandom, $urandom);
  endtask

  // one round, then the 255-round maximum with a decrypt of the encrypt
  task automatic test_round_extremes();
    xtea_in_t  plain;
    xtea_out_t coded;
    load_settings($urandom, $urandom, $urandom, $urandom, 32'd1);
    send_word(OP_ENCRYPT, $urandom, $urandom);
    send_word(OP_DECRYPT, $urandom, $urandom);
    load_settings($urandom, $urandom, $urandom, $urandom, 32'd255);
    plain = {OP_ENCRYPT, 32'($urandom), 32'($urandom)};
    send_word(plain.opcode, plain.data_first, plain.data_second);
    coded = predict_block(plain);
    send_word(OP_DECRYPT, coded.result_first, coded.result_second);
  endtask

  // round count takes only the low byte; unused indexes must be ignored
  task automatic test_register_masking();
    load_settings($urandom, $urandom, $urandom, $urandom, 32'hFFFF_FF03);
    for (int idx = int'(CFG_ROUND_COUNT) + 1; idx < (1 << CFG_IDX_W); idx++)
      write_reg(CFG_IDX_W'(idx), $urandom);
    send_word(OP_ENCRYPT, $urandom, $urandom);
    send_word(OP_DECRYPT, $urandom, $urandom);
  endtask

  // Random words under a fresh key; about a third are decrypts of a
  // predicted ciphertext so round trips get exercised. Halfway through the
  // sender waits for every result before carrying on.
  task automatic test_random_traffic(input int idle_pct, input int stall_pct);
    xtea_in_t   w;
    xtea_out_t  coded;
    logic [7:0] r;
    r = ($urandom_range(2) == 0) ? 8'($urandom_range(2, 40)) : 8'd32;
    load_settings($urandom, $urandom, $urandom, $urandom, {24'd0, r});
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      w = {1'($urandom), random_half(), random_half()};
      if ($urandom_range(9) < 3) begin
        w.opcode = OP_ENCRYPT;
        coded = predict_block(w);
        send_word(OP_DECRYPT, coded.result_first, coded.result_second);
      end else begin
        send_word(w.opcode, w.data_first, w.data_second);
      end
      if (i == RANDOM_WORDS / 2)
        drain_results();
    end
  endtask

  // Long receiver hold-off while words keep coming: the engine and its output
  // register fill and the input has to stall.
  task automatic test_backpressure();
    drain_results();
    sender_idle_pct    = 0;
    receiver_stall_pct = 15;
    holdoff_left <= HOLDOFF_CYCLES;
    for (int i = 0; i < 8; i++)
      send_word(1'($urandom), $urandom, $urandom);
  endtask

  initial begin
    cipher_key  = '{default: '0};
    round_total = RESET_ROUNDS;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_data_extremes();
    test_zero_rounds();
    test_round_extremes();
    test_register_masking();
    test_random_traffic(0, 0);
    test_random_traffic(51, 0);
    test_random_traffic(0, 51);
    test_random_traffic(15, 15);
    test_backpressure();

    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    drain_results();
    // let any stray word surface before the verdict
    repeat (2 * int'(round_total) + 10) @(posedge clk);
    foreach (expected_blocks[i])
      report_mismatch($sformatf("expected word %h never arrived", expected_blocks[i]));

    $display("Ran %0d words (%0d checked) under %0d key/round settings, 0 to 255 rounds,",
             words_sent, words_checked, settings_used);
    $display("with encrypt/decrypt round trips, idle/stall mixes and an output hold-off.");
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
